// ----- design/chst_pkg.sv -----
// shared types, constants and helpers for the cubic hermite spline table
package chst_pkg;

  localparam int MAX_POINTS  = 16;
  localparam int T_FRAC_BITS = 16;
  localparam int IDX_W       = $clog2(MAX_POINTS);
  localparam int CNT_W       = $clog2(MAX_POINTS + 1);
  localparam int T_W         = 20;
  localparam int SEG_W       = T_W - T_FRAC_BITS;
  localparam int TEN_W       = 19;
  localparam int MA_W        = 20;
  localparam int MB_W        = 33;
  localparam int PW          = MA_W + MB_W;
  localparam int ACC_W       = PW + 3;
  localparam int CARD_SHIFT  = 17;
  localparam int IN_DW       = 160;
  localparam int OUT_DW      = 136;

  typedef enum logic [3:0] {
    OP_APPEND   = 4'd0,
    OP_INSERT   = 4'd1,
    OP_REMOVE   = 4'd2,
    OP_SET_PT   = 4'd3,
    OP_SET_POS  = 4'd4,
    OP_SET_VEL  = 4'd5,
    OP_CLEAR    = 4'd6,
    OP_CARDINAL = 4'd7,
    OP_READ     = 4'd8,
    OP_EVAL_CUM = 4'd9,
    OP_EVAL_NRM = 4'd10
  } op_t;

  typedef enum logic [1:0] {
    STS_OK    = 2'd0,
    STS_RANGE = 2'd1,
    STS_FULL  = 2'd2,
    STS_FEW   = 2'd3
  } sts_t;

  typedef enum logic [4:0] {
    ST_IDLE, ST_DISPATCH, ST_INS, ST_INS_WR, ST_REM, ST_REM_WR, ST_RD_WAIT,
    ST_CD_RA, ST_CD_RB, ST_CD_MX, ST_CD_MY, ST_CD_WR, ST_EV_NORM, ST_EV_T2,
    ST_EV_T3, ST_EV_T3W, ST_EV_H, ST_EV_MAC, ST_DONE
  } state_t;

  typedef struct packed {
    logic acc_load;
    logic acc_add;
  } mac_ctrl_t;

  function automatic logic signed [31:0] rnd_sat(input logic signed [ACC_W-1:0] v,
                                                 input int unsigned sh);
    logic signed [ACC_W-1:0] s;
    logic signed [ACC_W-1:0] hi;
    logic signed [ACC_W-1:0] lo;
    hi = {{(ACC_W-32){1'b0}}, 32'h7fffffff};
    lo = {{(ACC_W-32){1'b1}}, 32'h80000000};
    s  = (v + (ACC_W'(1) << (sh - 1))) >>> sh;
    if (s > hi) return hi[31:0];
    if (s < lo) return lo[31:0];
    return s[31:0];
  endfunction

endpackage

// ----- design/chst_ram.sv -----
// generic single write, single read ram with registered read data
module chst_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ----- design/chst_mac.sv -----
// shared signed multiplier with registered product and accumulator
module chst_mac
  import chst_pkg::*;
(
  input  logic                    clk,
  input  logic signed [MA_W-1:0]  mul_a,
  input  logic signed [MB_W-1:0]  mul_b,
  input  mac_ctrl_t               ctrl,
  output logic signed [PW-1:0]    prod,
  output logic signed [ACC_W-1:0] acc
);

  logic signed [PW-1:0]    prod_r;
  logic signed [ACC_W-1:0] acc_r;
  logic signed [ACC_W-1:0] prod_ext;

  assign prod_ext = {{(ACC_W-PW){prod_r[PW-1]}}, prod_r};

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    if (ctrl.acc_load) begin
      acc_r <= prod_ext;
    end else if (ctrl.acc_add) begin
      acc_r <= acc_r + prod_ext;
    end
  end

  assign prod = prod_r;
  assign acc  = acc_r;

endmodule

// ----- design/cubic_hermite_spline_table.sv -----
// cubic hermite spline point table: sequencer, point memories and shared multiplier
// remove and insert move the stored points one at a time, cardinal updates each inner
// point in turn, normalized evaluation first scales the parameter by the segment count;
// one item at a time, next accepted on return to idle
// run time set by the single read port of the point memories and the one shared multiplier
// reset clears the point count, tension and output valid; point memory is not initialized
module cubic_hermite_spline_table
  import chst_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  input  logic [IN_DW-1:0]  in_tdata,   // point_index, pos_x, pos_y, vel_x, vel_y, param_t
  input  logic [3:0]        in_tuser,   // opcode
  output logic              out_tvalid,
  input  logic              out_tready,
  output logic [OUT_DW-1:0] out_tdata,  // out_x, out_y, out_vx, out_vy, point_count, status
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [TEN_W-1:0]  cfg_data
);

  state_t state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [TEN_W-1:0] tension_r;
  logic out_tvalid_r, out_tvalid_nxt;

  op_t op_r;
  logic [4:0] idx_r;
  logic [31:0] px_r, py_r, vx_r, vy_r;
  logic [T_W-1:0] pt_r;

  logic [CNT_W-1:0] ptr_r, ptr_nxt;
  logic [3:0] kstep_r, kstep_nxt;
  logic [IDX_W-1:0] seg_r, seg_nxt;
  logic [T_FRAC_BITS-1:0] t_r, t_nxt, t2_r, t2_nxt, t3_r, t3_nxt;
  logic signed [MA_W-1:0] h_r [4];
  logic signed [MA_W-1:0] h_nxt [4];
  logic [63:0] pa_r, pa_nxt, va_r, va_nxt, pb_r, pb_nxt, vb_r, vb_nxt;
  logic [63:0] apos_r, apos_nxt, bpos_r, bpos_nxt;
  logic [31:0] cvx_r, cvx_nxt;
  logic [31:0] rx_r, rx_nxt, ry_r, ry_nxt, rvx_r, rvx_nxt, rvy_r, rvy_nxt;
  sts_t rst_r, rst_nxt;
  logic [OUT_DW-1:0] out_r, out_nxt;

  logic pos_we, vel_we;
  logic [IDX_W-1:0] waddr, raddr;
  logic [63:0] pos_wdata, vel_wdata, pos_rdata, vel_rdata;

  logic signed [MA_W-1:0] mul_a;
  logic signed [MB_W-1:0] mul_b;
  mac_ctrl_t mac_ctrl;
  logic signed [PW-1:0] prod;
  logic signed [ACC_W-1:0] acc, prod_ext;

  logic in_acc;
  logic [CNT_W-1:0] nm1, ptr_p1, ptr_m1;
  logic signed [MA_W-1:0] k_w;
  logic [63:0] src_dat;
  logic [31:0] term_dat;

  assign in_acc    = in_tvalid & in_tready;
  assign in_tready = (state_r == ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = out_r;
  assign nm1    = count_r - CNT_W'(1);
  assign ptr_p1 = ptr_r + CNT_W'(1);
  assign ptr_m1 = ptr_r - CNT_W'(1);
  assign k_w    = MA_W'(1 << T_FRAC_BITS) - {tension_r[TEN_W-1], tension_r};
  assign prod_ext = {{(ACC_W-PW){prod[PW-1]}}, prod};

  chst_ram #(.WIDTH(64), .DEPTH(MAX_POINTS)) u_pos_ram (
    .clk(clk), .we(pos_we), .waddr(waddr), .wdata(pos_wdata),
    .raddr(raddr), .rdata(pos_rdata)
  );

  chst_ram #(.WIDTH(64), .DEPTH(MAX_POINTS)) u_vel_ram (
    .clk(clk), .we(vel_we), .waddr(waddr), .wdata(vel_wdata),
    .raddr(raddr), .rdata(vel_rdata)
  );

  chst_mac u_mac (
    .clk(clk), .mul_a(mul_a), .mul_b(mul_b), .ctrl(mac_ctrl),
    .prod(prod), .acc(acc)
  );

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) state_nxt = ST_DISPATCH;
      end
      ST_DISPATCH: begin
        state_nxt = ST_DONE;
        case (op_r)
          OP_INSERT: begin
            if (idx_r <= 5'(count_r) && count_r < CNT_W'(MAX_POINTS)) state_nxt = ST_INS;
          end
          OP_REMOVE: begin
            if (idx_r < 5'(count_r)) state_nxt = ST_REM;
          end
          OP_CARDINAL: begin
            if (count_r >= CNT_W'(3)) state_nxt = ST_CD_RA;
          end
          OP_READ: begin
            if (idx_r < 5'(count_r)) state_nxt = ST_RD_WAIT;
          end
          OP_EVAL_CUM: begin
            if (count_r >= CNT_W'(2) && CNT_W'(pt_r[T_W-1:T_FRAC_BITS]) < nm1)
              state_nxt = ST_EV_T2;
          end
          OP_EVAL_NRM: begin
            if (count_r >= CNT_W'(2)) state_nxt = ST_EV_NORM;
          end
          default: state_nxt = ST_DONE;
        endcase
      end
      ST_INS:     state_nxt = (ptr_r == CNT_W'(idx_r)) ? ST_DONE : ST_INS_WR;
      ST_INS_WR:  state_nxt = ST_INS;
      ST_REM:     state_nxt = (ptr_p1 < count_r) ? ST_REM_WR : ST_DONE;
      ST_REM_WR:  state_nxt = ST_REM;
      ST_RD_WAIT: state_nxt = ST_DONE;
      ST_CD_RA:   state_nxt = (ptr_p1 < count_r) ? ST_CD_RB : ST_DONE;
      ST_CD_RB:   state_nxt = ST_CD_MX;
      ST_CD_MX:   state_nxt = ST_CD_MY;
      ST_CD_MY:   state_nxt = ST_CD_WR;
      ST_CD_WR:   state_nxt = ST_CD_RA;
      ST_EV_NORM: state_nxt = ST_EV_T2;
      ST_EV_T2:   state_nxt = ST_EV_T3;
      ST_EV_T3:   state_nxt = ST_EV_T3W;
      ST_EV_T3W:  state_nxt = ST_EV_H;
      ST_EV_H:    state_nxt = ST_EV_MAC;
      ST_EV_MAC:  state_nxt = (kstep_r == 4'd9) ? ST_DONE : ST_EV_MAC;
      ST_DONE: begin
        if (!out_tvalid_r || out_tready) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // datapath control
  always_comb begin
    count_nxt = count_r;
    out_tvalid_nxt = out_tvalid_r & ~out_tready;
    out_nxt = out_r;
    ptr_nxt = ptr_r;
    kstep_nxt = kstep_r;
    seg_nxt = seg_r;
    t_nxt = t_r;
    t2_nxt = t2_r;
    t3_nxt = t3_r;
    h_nxt = h_r;
    pa_nxt = pa_r;
    va_nxt = va_r;
    pb_nxt = pb_r;
    vb_nxt = vb_r;
    apos_nxt = apos_r;
    bpos_nxt = bpos_r;
    cvx_nxt = cvx_r;
    rx_nxt = rx_r;
    ry_nxt = ry_r;
    rvx_nxt = rvx_r;
    rvy_nxt = rvy_r;
    rst_nxt = rst_r;
    pos_we = 1'b0;
    vel_we = 1'b0;
    waddr = ptr_r[IDX_W-1:0];
    raddr = ptr_r[IDX_W-1:0];
    pos_wdata = {py_r, px_r};
    vel_wdata = {vy_r, vx_r};
    mul_a = '0;
    mul_b = '0;
    mac_ctrl = '0;
    src_dat = '0;
    term_dat = '0;
    unique case (state_r)
      ST_IDLE: begin
        rx_nxt = '0;
        ry_nxt = '0;
        rvx_nxt = '0;
        rvy_nxt = '0;
        rst_nxt = STS_OK;
      end
      ST_DISPATCH: begin
        ptr_nxt = CNT_W'(idx_r);
        case (op_r) inside
          OP_APPEND: begin
            if (count_r >= CNT_W'(MAX_POINTS)) begin
              rst_nxt = STS_FULL;
            end else begin
              waddr = count_r[IDX_W-1:0];
              pos_we = 1'b1;
              vel_we = 1'b1;
              count_nxt = count_r + CNT_W'(1);
            end
          end
          OP_INSERT: begin
            if (idx_r > 5'(count_r)) rst_nxt = STS_RANGE;
            else if (count_r >= CNT_W'(MAX_POINTS)) rst_nxt = STS_FULL;
            else ptr_nxt = count_r;
          end
          OP_REMOVE, OP_READ: begin
            raddr = idx_r[IDX_W-1:0];
            if (idx_r >= 5'(count_r)) rst_nxt = STS_RANGE;
          end
          OP_SET_PT, OP_SET_POS, OP_SET_VEL: begin
            waddr = idx_r[IDX_W-1:0];
            if (idx_r >= 5'(count_r)) begin
              rst_nxt = STS_RANGE;
            end else begin
              pos_we = (op_r != OP_SET_VEL);
              vel_we = (op_r != OP_SET_POS);
            end
          end
          OP_CLEAR: count_nxt = '0;
          OP_CARDINAL: begin
            ptr_nxt = CNT_W'(1);
            if (count_r < CNT_W'(3)) rst_nxt = STS_FEW;
          end
          OP_EVAL_CUM: begin
            seg_nxt = IDX_W'(pt_r[T_W-1:T_FRAC_BITS]);
            t_nxt = pt_r[T_FRAC_BITS-1:0];
            if (count_r < CNT_W'(2)) rst_nxt = STS_FEW;
            else if (CNT_W'(pt_r[T_W-1:T_FRAC_BITS]) >= nm1) rst_nxt = STS_RANGE;
          end
          OP_EVAL_NRM: begin
            mul_a = MA_W'(nm1);
            mul_b = MB_W'(pt_r[T_FRAC_BITS-1:0]);
            if (count_r < CNT_W'(2)) rst_nxt = STS_FEW;
          end
          default: rst_nxt = STS_OK;
        endcase
      end
      ST_INS: begin
        raddr = ptr_m1[IDX_W-1:0];
        if (ptr_r == CNT_W'(idx_r)) begin
          pos_we = 1'b1;
          vel_we = 1'b1;
          count_nxt = count_r + CNT_W'(1);
        end
      end
      ST_INS_WR: begin
        pos_we = 1'b1;
        vel_we = 1'b1;
        pos_wdata = pos_rdata;
        vel_wdata = vel_rdata;
        ptr_nxt = ptr_m1;
      end
      ST_REM: begin
        raddr = ptr_p1[IDX_W-1:0];
        if (ptr_p1 >= count_r) count_nxt = nm1;
      end
      ST_REM_WR: begin
        pos_we = 1'b1;
        vel_we = 1'b1;
        pos_wdata = pos_rdata;
        vel_wdata = vel_rdata;
        ptr_nxt = ptr_p1;
      end
      ST_RD_WAIT: begin
        rx_nxt = pos_rdata[31:0];
        ry_nxt = pos_rdata[63:32];
        rvx_nxt = vel_rdata[31:0];
        rvy_nxt = vel_rdata[63:32];
      end
      ST_CD_RA: raddr = ptr_p1[IDX_W-1:0];
      ST_CD_RB: begin
        raddr = ptr_m1[IDX_W-1:0];
        apos_nxt = pos_rdata;
      end
      ST_CD_MX: begin
        bpos_nxt = pos_rdata;
        mul_a = k_w;
        mul_b = {apos_r[31], apos_r[31:0]} - {pos_rdata[31], pos_rdata[31:0]};
      end
      ST_CD_MY: begin
        mul_a = k_w;
        mul_b = {apos_r[63], apos_r[63:32]} - {bpos_r[63], bpos_r[63:32]};
        cvx_nxt = rnd_sat(prod_ext, CARD_SHIFT);
      end
      ST_CD_WR: begin
        vel_we = 1'b1;
        vel_wdata = {rnd_sat(prod_ext, CARD_SHIFT), cvx_r};
        ptr_nxt = ptr_p1;
      end
      ST_EV_NORM: begin
        seg_nxt = prod[T_FRAC_BITS+IDX_W-1:T_FRAC_BITS];
        t_nxt = prod[T_FRAC_BITS-1:0];
      end
      ST_EV_T2: begin
        raddr = seg_r;
        mul_a = MA_W'(t_r);
        mul_b = MB_W'(t_r);
      end
      ST_EV_T3: begin
        raddr = seg_r + IDX_W'(1);
        t2_nxt = prod[2*T_FRAC_BITS-1:T_FRAC_BITS];
        mul_a = MA_W'(t2_nxt);
        mul_b = MB_W'(t_r);
        pa_nxt = pos_rdata;
        va_nxt = vel_rdata;
      end
      ST_EV_T3W: begin
        t3_nxt = prod[2*T_FRAC_BITS-1:T_FRAC_BITS];
        pb_nxt = pos_rdata;
        vb_nxt = vel_rdata;
      end
      ST_EV_H: begin
        h_nxt[0] = MA_W'(2 * MA_W'(t3_r) - 3 * MA_W'(t2_r) + MA_W'(1 << T_FRAC_BITS));
        h_nxt[1] = MA_W'(MA_W'(t3_r) - 2 * MA_W'(t2_r) + MA_W'(t_r));
        h_nxt[2] = MA_W'(3 * MA_W'(t2_r) - 2 * MA_W'(t3_r));
        h_nxt[3] = MA_W'(t3_r) - MA_W'(t2_r);
        kstep_nxt = '0;
      end
      ST_EV_MAC: begin
        case (kstep_r[1:0])
          2'd0: src_dat = pa_r;
          2'd1: src_dat = va_r;
          2'd2: src_dat = pb_r;
          default: src_dat = vb_r;
        endcase
        term_dat = kstep_r[2] ? src_dat[63:32] : src_dat[31:0];
        mul_a = h_r[kstep_r[1:0]];
        mul_b = {term_dat[31], term_dat};
        mac_ctrl.acc_load = (kstep_r == 4'd1) || (kstep_r == 4'd5);
        mac_ctrl.acc_add = (kstep_r >= 4'd2 && kstep_r <= 4'd4)
                        || (kstep_r >= 4'd6 && kstep_r <= 4'd8);
        if (kstep_r == 4'd5) rx_nxt = rnd_sat(acc, T_FRAC_BITS);
        if (kstep_r == 4'd9) ry_nxt = rnd_sat(acc, T_FRAC_BITS);
        kstep_nxt = kstep_r + 4'd1;
      end
      ST_DONE: begin
        if (!out_tvalid_r || out_tready) begin
          out_tvalid_nxt = 1'b1;
          out_nxt = {1'b0, rst_r, 5'(count_r), rvy_r, rvx_r, ry_r, rx_r};
        end
      end
      default: rst_nxt = rst_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= '0;
      tension_r <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      out_tvalid_r <= out_tvalid_nxt;
      if (cfg_valid && cfg_ready) begin
        tension_r <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      op_r  <= op_t'(in_tuser);
      idx_r <= in_tdata[4:0];
      px_r  <= in_tdata[36:5];
      py_r  <= in_tdata[68:37];
      vx_r  <= in_tdata[100:69];
      vy_r  <= in_tdata[132:101];
      pt_r  <= in_tdata[152:133];
    end
    ptr_r <= ptr_nxt;
    kstep_r <= kstep_nxt;
    seg_r <= seg_nxt;
    t_r <= t_nxt;
    t2_r <= t2_nxt;
    t3_r <= t3_nxt;
    h_r <= h_nxt;
    pa_r <= pa_nxt;
    va_r <= va_nxt;
    pb_r <= pb_nxt;
    vb_r <= vb_nxt;
    apos_r <= apos_nxt;
    bpos_r <= bpos_nxt;
    cvx_r <= cvx_nxt;
    rx_r <= rx_nxt;
    ry_r <= ry_nxt;
    rvx_r <= rvx_nxt;
    rvy_r <= rvy_nxt;
    rst_r <= rst_nxt;
    out_r <= out_nxt;
  end

  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_POINTS)) else $error("point count above table size");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> state_r != ST_IDLE) else $error("accepted transaction not started");

  a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[134:133] == STS_FULL |-> out_tdata[132:128] == 5'(MAX_POINTS))
    else $error("full status with room left");

  a_write_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (pos_we || vel_we) |-> CNT_W'(waddr) <= count_r)
    else $error("memory write beyond stored points");

endmodule
